>>> hdl/lru_pkg.sv
// Shared constants, types and helpers for the LRU tracker.
`timescale 1ns / 1ps
package lru_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ID_W    = 31;
  localparam int CFG_W   = 7;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ID_W-1:0]  id_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORD,
    ST_TAG,
    ST_CMP,
    ST_SHR,
    ST_SHW,
    ST_APP,
    ST_OUT
  } state_t;

  // Port requests toward the tag and recency-order memories.
  typedef struct packed {
    slot_t ord_raddr;
    logic  ord_we;
    slot_t ord_waddr;
    slot_t ord_wdata;
    slot_t tag_raddr;
    logic  tag_we;
    slot_t tag_waddr;
    id_t   tag_wdata;
  } mem_req_t;

  // Limit clamped to 1..ENTRIES.
  function automatic logic [CMP_W-1:0] eff_limit(input logic [CFG_W-1:0] cfg);
    logic [CMP_W-1:0] lim;
    lim = CMP_W'(cfg);
    if (cfg == '0) begin
      lim = CMP_W'(1);
    end else if (lim > CMP_W'(ENTRIES)) begin
      lim = CMP_W'(ENTRIES);
    end
    return lim;
  endfunction

endpackage

>>> hdl/lru_store.sv
// Tag and recency-order memories, one write and one registered read each.
`timescale 1ns / 1ps
module lru_store (
  input  logic              clk,
  input  lru_pkg::mem_req_t req,
  output lru_pkg::slot_t    ord_q,
  output lru_pkg::id_t      tag_q
);
  import lru_pkg::*;

  slot_t order_mem [ENTRIES];
  id_t   tag_mem   [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.ord_we) begin
      order_mem[req.ord_waddr] <= req.ord_wdata;
    end
    ord_q <= order_mem[req.ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.tag_we) begin
      tag_mem[req.tag_waddr] <= req.tag_wdata;
    end
    tag_q <= tag_mem[req.tag_raddr];
  end

endmodule

>>> hdl/lru_tracker_top.sv
// Top level of the fully associative LRU tracker.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid/in_stall) carries action, item_id, load_ok. The
//    block takes one transfer at a time; in_stall is high from acceptance
//    until the result has moved into the output register.
//  - Output channel (out_valid/out_stall) carries hit, inserted, evict_valid,
//    evicted_id and occupancy, one result per input transfer. The result sits
//    in an output register, so the next input transfer is taken while it
//    waits; a stalled receiver holds the result and, once a second result is
//    ready, keeps in_stall high until the first one leaves.
//  - Steps per item: a clear, or an access to an empty store, goes straight
//    to reporting (through an append when an insert follows). A lookup
//    walks positions from least to most recent, one shared compare on a
//    registered tag read after a registered order read; then a hit closes
//    the gap in the recency order and an eviction shifts the order, before
//    the append and report (a miss without load_ok only reports).
//  - capacity_limit is written through cfg_we/cfg_wdata; the user
//    writes it only while idle, which the block does not enforce; 0 acts
//    as 1, values above the store depth act as the depth.
//  - Synchronous reset empties the store (count to zero) and sets the limit
//    to 64; memory contents are not cleared since only occupied slots are read.
module lru_tracker_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lru_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  lru_pkg::id_t               item_id,
  input  logic                       load_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic                       inserted,
  output logic                       evict_valid,
  output lru_pkg::id_t               evicted_id,
  output lru_pkg::cnt_t              occupancy
);
  import lru_pkg::*;

  state_t state, state_next;

  // Occupied slots are always 0..count-1: an eviction hands its slot straight
  // to the new entry, a plain insert takes slot count.
  cnt_t             count, count_next;
  logic [CFG_W-1:0] cap;
  slot_t            pos, pos_next;
  slot_t            slot_r, slot_r_next;
  slot_t            first_slot, first_slot_next;
  id_t              first_tag, first_tag_next;
  slot_t            app_slot, app_slot_next;
  id_t              id_r;
  logic             load_r;
  logic             hit_r, hit_r_next;
  logic             ins_r, ins_r_next;
  logic             ev_r, ev_r_next;
  id_t              evid_r, evid_r_next;

  mem_req_t req;
  slot_t    ord_q;
  id_t      tag_q;

  logic in_xfer, out_free;
  logic last_pos, tag_match, need_evict, shift_more;
  cnt_t cnt_m1;

  lru_store u_store (
    .clk   (clk),
    .req   (req),
    .ord_q (ord_q),
    .tag_q (tag_q)
  );

  assign in_stall   = (state != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign last_pos   = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign tag_match  = (tag_q == id_r);
  assign need_evict = CMP_W'(count) >= eff_limit(cap);
  assign shift_more = (CNT_W'(pos) + CNT_W'(2)) < count;
  assign cnt_m1     = count - CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (action) begin
            state_next = ST_OUT;
          end else if (count == '0) begin
            state_next = load_ok ? ST_APP : ST_OUT;
          end else begin
            state_next = ST_ORD;
          end
        end
      end
      ST_ORD: state_next = ST_TAG;
      ST_TAG: state_next = ST_CMP;
      ST_CMP: begin
        if (tag_match) begin
          state_next = last_pos ? ST_APP : ST_SHR;
        end else if (last_pos) begin
          if (!load_r) begin
            state_next = ST_OUT;
          end else if (need_evict && count > CNT_W'(1)) begin
            state_next = ST_SHR;
          end else begin
            state_next = ST_APP;
          end
        end else begin
          state_next = ST_ORD;
        end
      end
      ST_SHR: state_next = ST_SHW;
      ST_SHW: state_next = shift_more ? ST_SHR : ST_APP;
      ST_APP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and register next values.
  always_comb begin
    count_next      = count;
    pos_next        = pos;
    slot_r_next     = slot_r;
    first_slot_next = first_slot;
    first_tag_next  = first_tag;
    app_slot_next   = app_slot;
    hit_r_next      = hit_r;
    ins_r_next      = ins_r;
    ev_r_next       = ev_r;
    evid_r_next     = evid_r;
    req             = '0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          hit_r_next  = 1'b0;
          ins_r_next  = 1'b0;
          ev_r_next   = 1'b0;
          evid_r_next = '0;
          pos_next    = '0;
          if (action) begin
            count_next = '0;
          end else if (count == '0 && load_ok) begin
            ins_r_next    = 1'b1;
            app_slot_next = '0;
            count_next    = CNT_W'(1);
          end
        end
      end
      ST_ORD: begin
        req.ord_raddr = pos;
      end
      ST_TAG: begin
        req.tag_raddr = ord_q;
        slot_r_next   = ord_q;
      end
      ST_CMP: begin
        if (pos == '0) begin
          first_slot_next = slot_r;
          first_tag_next  = tag_q;
        end
        if (tag_match) begin
          hit_r_next    = 1'b1;
          app_slot_next = slot_r;
        end else if (last_pos) begin
          if (load_r) begin
            ins_r_next = 1'b1;
            if (need_evict) begin
              // Oldest entry leaves; its slot takes the new identifier.
              ev_r_next     = 1'b1;
              evid_r_next   = (pos == '0) ? tag_q : first_tag;
              app_slot_next = (pos == '0) ? slot_r : first_slot;
              pos_next      = '0;
            end else begin
              app_slot_next = count[IDX_W-1:0];
              count_next    = count + CNT_W'(1);
            end
          end
        end else begin
          pos_next = pos + IDX_W'(1);
        end
      end
      ST_SHR: begin
        req.ord_raddr = pos + IDX_W'(1);
      end
      ST_SHW: begin
        req.ord_we    = 1'b1;
        req.ord_waddr = pos;
        req.ord_wdata = ord_q;
        pos_next      = pos + IDX_W'(1);
      end
      ST_APP: begin
        req.ord_we    = 1'b1;
        req.ord_waddr = cnt_m1[IDX_W-1:0];
        req.ord_wdata = app_slot;
        req.tag_we    = ins_r;
        req.tag_waddr = app_slot;
        req.tag_wdata = id_r;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      cap   <= CFG_W'(64);
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    slot_r     <= slot_r_next;
    first_slot <= first_slot_next;
    first_tag  <= first_tag_next;
    app_slot   <= app_slot_next;
    hit_r      <= hit_r_next;
    ins_r      <= ins_r_next;
    ev_r       <= ev_r_next;
    evid_r     <= evid_r_next;
    if (in_xfer) begin
      id_r   <= item_id;
      load_r <= load_ok;
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      hit         <= hit_r;
      inserted    <= ins_r;
      evict_valid <= ev_r;
      evicted_id  <= evid_r;
      occupancy   <= count;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("occupancy beyond store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action) |=> (count == '0))
    else $error("clear left entries behind");

  a_hit_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (!inserted && !evict_valid))
    else $error("hit reported together with insert or evict");

  a_evict_implies_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evict_valid) |-> inserted)
    else $error("eviction without insertion");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && state_next == ST_SHR && !tag_match) |=> $stable(count))
    else $error("eviction path changed occupancy");

endmodule

>>> tb/tb_lru_tracker_top.sv
// Self-checking testbench for the LRU tracker: directed rows, then random traffic vs. a predictor.
`timescale 1ns / 1ps
module tb_lru_tracker_top;
  import lru_pkg::*;

  // Action codes on the input channel.
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Worst single item: a full 64-entry walk plus a full order shift. The drain
  // wait and the watchdog are sized from that.
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLDOFF      = 1000;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int POOL_N       = 128;
  localparam int N_DIR        = 19;

  typedef struct packed {
    logic hit;
    logic inserted;
    logic evict_valid;
    id_t  evicted_id;
    cnt_t occupancy;
  } lru_result_t;

  // One directed row; 'typed' rows carry a hand-derived result, the rest use
  // the predictor.
  typedef struct {
    logic        op;
    id_t         id;
    logic        load_ok;
    bit          typed;
    lru_result_t want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_ACCESS;
  id_t  item_id = '0;
  logic load_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic inserted;
  logic evict_valid;
  id_t  evicted_id;
  cnt_t occupancy;

  lru_tracker_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .item_id     (item_id),
    .load_ok     (load_ok),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .inserted    (inserted),
    .evict_valid (evict_valid),
    .evicted_id  (evicted_id),
    .occupancy   (occupancy)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: slot tags, slot in-use flags, recency order (index 0 is
  // least recent) and the entry count, plus the shadow of capacity_limit.
  // ---------------------------------------------------------------------------
  id_t              shadow_tag   [ENTRIES];
  logic             shadow_used  [ENTRIES];
  int               shadow_order [ENTRIES];
  int               shadow_count = 0;
  logic [CFG_W-1:0] shadow_limit = CFG_W'(64);

  lru_result_t pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_reqs = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  id_t         id_pool [POOL_N];

  // Directed rows, run with capacity_limit = 2. Typed rows are easy to work out
  // by hand; the tail is left to the predictor.
  stim_row_t dir_rows [N_DIR] = '{
    // miss without load on empty store: no change
    '{ACT_ACCESS, 31'h00000000, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 31'h0, 7'd0}},
    '{ACT_ACCESS, 31'h00000000, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 31'h0, 7'd1}},
    '{ACT_ACCESS, 31'h7FFFFFFF, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 31'h0, 7'd2}},
    // hit on id 0 makes 7FFFFFFF least recent
    '{ACT_ACCESS, 31'h00000000, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 31'h0, 7'd2}},
    '{ACT_ACCESS, 31'h55555555, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 31'h7FFFFFFF, 7'd2}},
    '{ACT_ACCESS, 31'h7FFFFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 31'h0, 7'd2}},
    '{ACT_ACCESS, 31'h2AAAAAAA, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 31'h0, 7'd2}},
    '{ACT_ACCESS, 31'h55555555, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 31'h0, 7'd2}},
    // clear ignores id and load_ok
    '{ACT_CLEAR,  31'h7FFFFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 31'h0, 7'd0}},
    '{ACT_ACCESS, 31'h2AAAAAAA, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 31'h0, 7'd0}},
    '{ACT_CLEAR,  31'h00000000, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 31'h0, 7'd0}},
    '{ACT_ACCESS, 31'h00000001, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 31'h0, 7'd1}},
    '{ACT_ACCESS, 31'h00000002, 1'b1, 1'b0, '0},
    '{ACT_ACCESS, 31'h00000001, 1'b1, 1'b0, '0},
    '{ACT_ACCESS, 31'h00000003, 1'b1, 1'b0, '0},
    '{ACT_ACCESS, 31'h00000003, 1'b0, 1'b0, '0},
    '{ACT_ACCESS, 31'h40000000, 1'b1, 1'b0, '0},
    '{ACT_ACCESS, 31'h00000001, 1'b0, 1'b0, '0},
    '{ACT_CLEAR,  31'h12345678, 1'b0, 1'b0, '0}
  };

  // Applies one transfer to the shadow store and returns the result it should
  // produce.
  function automatic lru_result_t lru_lookup(input logic op, input id_t id, input logic lo);
    lru_result_t r;
    int          found;
    int          slot;
    int          lim;
    r = '0;
    found = -1;
    if (op == ACT_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_count = 0;
    end else begin
      for (int p = 0; p < shadow_count; p++) begin
        if (found < 0 && shadow_used[shadow_order[p]] &&
            shadow_tag[shadow_order[p]] == id) begin
          found = p;
        end
      end
      if (found >= 0) begin
        // hit: move to the most recent end
        slot = shadow_order[found];
        for (int p = found; p + 1 < shadow_count; p++) shadow_order[p] = shadow_order[p + 1];
        shadow_order[shadow_count - 1] = slot;
        r.hit = 1'b1;
      end else if (lo) begin
        lim = int'(shadow_limit);
        if (lim < 1) lim = 1;
        if (lim > ENTRIES) lim = ENTRIES;
        // at most one eviction per insert, even when the limit was lowered
        if (shadow_count + 1 > lim && shadow_count > 0) begin
          slot = shadow_order[0];
          r.evict_valid = 1'b1;
          r.evicted_id  = shadow_tag[slot];
          shadow_used[slot] = 1'b0;
          for (int p = 0; p + 1 < shadow_count; p++) shadow_order[p] = shadow_order[p + 1];
          shadow_count--;
        end
        slot = -1;
        for (int s = ENTRIES - 1; s >= 0; s--) if (!shadow_used[s]) slot = s;
        if (slot >= 0 && shadow_count < ENTRIES) begin
          shadow_tag[slot]  = id;
          shadow_used[slot] = 1'b1;
          shadow_order[shadow_count] = slot;
          shadow_count++;
          r.inserted = 1'b1;
        end
      end
    end
    r.occupancy = cnt_t'(shadow_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. valid stays high across back-to-back transfers; it is only
  // lowered on an idle cycle or at the end of a phase, so it never gets two
  // assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic drive_item(input logic op, input id_t id, input logic lo, input bit typed,
                            input lru_result_t want);
    lru_result_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= op;
    item_id  <= id;
    load_ok  <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    predicted = lru_lookup(op, id, lo);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  // capacity_limit is only written with nothing in flight.
  task automatic set_limit(input logic [CFG_W-1:0] v);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_limit = v;
  endtask

  // Random accesses drawn mostly from the first pool_n ids of a shared pool so
  // hits and evictions are frequent; the rest are fully random ids.
  task automatic run_segment(input logic [CFG_W-1:0] lim, input int n_items, input int pool_n,
                             input int clear_pct, input int load_pct);
    logic op;
    id_t  id;
    logic lo;
    set_limit(lim);
    for (int k = 0; k < n_items; k++) begin
      op = ($urandom_range(99) < clear_pct) ? ACT_CLEAR : ACT_ACCESS;
      if ($urandom_range(99) < 85) id = id_pool[$urandom_range(pool_n - 1)];
      else id = id_t'($urandom());
      lo = ($urandom_range(99) < load_pct);
      drive_item(op, id, lo, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request. The hold-off
  // is counted here so the sender keeps offering transfers meanwhile.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_stall <= 1'b1;
      hold_done <= hold_done + 1;
      hold_left <= HOLDOFF;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {hit, inserted, evict_valid, evicted_id, occupancy};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: hit=%0b ins=%0b ev=%0b id=%h occ=%0d",
                   got.hit, got.inserted, got.evict_valid, got.evicted_id, got.occupancy);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.hit !== want.hit || got.inserted !== want.inserted ||
            got.evict_valid !== want.evict_valid || got.evicted_id !== want.evicted_id ||
            got.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("ERROR: exp hit=%0b ins=%0b ev=%0b id=%h occ=%0d",
                   want.hit, want.inserted, want.evict_valid, want.evicted_id, want.occupancy);
            $display(" / got hit=%0b ins=%0b ev=%0b id=%h occ=%0d",
                     got.hit, got.inserted, got.evict_valid, got.evicted_id, got.occupancy);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed rows at limit 2, then random phases across the
  // limit range (0 acts as 1, 127 acts as the store depth). Phase 3 fills the
  // store to see full-store eviction, phase 4 drops the limit below the
  // occupancy it leaves behind.
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shadow_used[i]) begin
      shadow_used[i]  = 1'b0;
      shadow_tag[i]   = '0;
      shadow_order[i] = 0;
    end
    foreach (id_pool[i]) id_pool[i] = id_t'($urandom());
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles rarely, receiver often
    snd_idle_pct = 14;
    rcv_idle_pct = 71;
    set_limit(CFG_W'(2));
    for (int k = 0; k < N_DIR; k++)
      drive_item(dir_rows[k].op, dir_rows[k].id, dir_rows[k].load_ok, dir_rows[k].typed,
                 dir_rows[k].want);
    in_valid <= 1'b0;
    run_segment(CFG_W'(0), 40, 4, 5, 80);
    run_segment(CFG_W'(8), 100, 14, 3, 80);

    // roles swapped
    snd_idle_pct = 71;
    rcv_idle_pct = 14;
    run_segment(CFG_W'(127), 160, 120, 0, 95);
    run_segment(CFG_W'(3), 60, 80, 0, 70);

    // no idling; one long receiver hold-off so the block backs up
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    hold_reqs = hold_reqs + 1;
    run_segment(CFG_W'(64), 160, 90, 2, 85);
    run_segment(CFG_W'(1), 60, 3, 5, 80);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
